// File: hw/rtl/eg_pkg.sv
package eg_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 17;
    localparam int GAIN_W    = 33;
    localparam int STEP_W    = 34;
    localparam int NUM_W     = 33;
    localparam int CNT_W     = 6;
    localparam int PROD_W    = 50;
    localparam int REG_IDX_W = 3;
    localparam int Q_DEPTH   = 2;

    localparam logic [REG_IDX_W-1:0] REG_ATTACK_LENGTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_LENGTH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DECAY_LENGTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOTAL_LENGTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FULL_GAIN     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK_LEVEL  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_ENABLES = 3'd7;

    localparam logic [LEVEL_W-1:0] UNITY_LEVEL = 17'd65536;

    typedef struct packed {
        logic [LEVEL_W-1:0] full_gain;
        logic [LEVEL_W-1:0] attack_level;
        logic [LEVEL_W-1:0] sustain_level;
        logic [1:0]         phase_enables;
    } eg_levels_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic [GAIN_W-1:0]          gain;
    } eg_item_t;

endpackage

// File: hw/rtl/eg_div.sv
module eg_div
    import eg_pkg::*;
#(
    parameter int LENGTH_BITS = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     neg,
    input  logic [NUM_W-1:0]         num,
    input  logic [LENGTH_BITS-1:0]   den,
    output logic                     done,
    output logic signed [STEP_W-1:0] quotient
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_W - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic                   neg_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [NUM_W-1:0]       quo_reg;
    logic [LENGTH_BITS-1:0] den_reg;
    logic [LENGTH_BITS-1:0] rem_reg;

    logic [LENGTH_BITS:0]   rem_shift;
    logic [LENGTH_BITS:0]   rem_diff;
    logic                   fits;
    logic [LENGTH_BITS-1:0] rem_next;

    // Restoring division, one quotient bit per cycle.
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_next  = fits ? rem_diff[LENGTH_BITS-1:0] : rem_shift[LENGTH_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            neg_reg <= neg;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// File: hw/rtl/eg_front.sv
module eg_front
    import eg_pkg::*;
#(
    parameter int LENGTH_BITS = 20
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       last_in_buffer,
    output logic                       full,
    input  logic [LENGTH_BITS-1:0]     attack_length,
    input  logic [LENGTH_BITS-1:0]     hold_length,
    input  logic [LENGTH_BITS-1:0]     decay_length,
    input  logic [LENGTH_BITS-1:0]     total_length,
    input  eg_levels_t                 levels,
    output logic                       q_push,
    output eg_item_t                   q_item,
    input  logic                       q_full
);

    localparam int EXT_W = LENGTH_BITS + 2;

    localparam logic [2:0] PH_ATTACK  = 3'd0;
    localparam logic [2:0] PH_HOLD    = 3'd1;
    localparam logic [2:0] PH_DECAY   = 3'd2;
    localparam logic [2:0] PH_SUSTAIN = 3'd3;
    localparam logic [2:0] PH_DECAY2  = 3'd4;
    localparam logic [2:0] PH_SILENT  = 3'd5;

    localparam logic ST_EVAL = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

    logic                       state_reg, state_next;
    logic                       hold_reg, hold_next;
    logic                       started_reg, started_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic [LENGTH_BITS-1:0]     pos_reg, pos_next;
    logic [2:0]                 phase_reg, phase_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic signed [STEP_W-1:0]   step_reg, step_next;
    logic [LEVEL_W-1:0]         end_reg, end_next;

    logic                       accept;
    logic                       emit;
    logic                       div_start;
    logic [LEVEL_W-1:0]         div_from;
    logic [LEVEL_W-1:0]         div_to;
    logic [LENGTH_BITS-1:0]     div_len;
    logic                       div_done;
    logic signed [STEP_W-1:0]   div_q;
    logic signed [LEVEL_W:0]    diff;
    logic [LEVEL_W-1:0]         diff_mag;

    logic [EXT_W-1:0]           pos_ext;
    logic [EXT_W-1:0]           total_ext;
    logic [EXT_W-1:0]           ah_end;
    logic [EXT_W-1:0]           ahd_end;
    logic [EXT_W-1:0]           tail_start;
    logic [EXT_W-1:0]           tail_len;
    logic [LEVEL_W-1:0]         tail_level;
    logic                       need_start;
    logic signed [STEP_W:0]     gain_sum;
    logic [GAIN_W-1:0]          gain_clamped;

    assign pos_ext    = EXT_W'(pos_reg);
    assign total_ext  = EXT_W'(total_length);
    assign ah_end     = EXT_W'(attack_length) + EXT_W'(hold_length);
    assign ahd_end    = ah_end + EXT_W'(decay_length);
    assign tail_start = levels.phase_enables[0] ? ahd_end : ah_end;
    assign tail_len   = total_ext - tail_start;
    assign need_start = (pos_reg == '0) && (phase_reg == PH_ATTACK) && !started_reg;

    // Without a decay phase the tail starts from full gain.
    assign tail_level = (phase_reg == PH_HOLD) ? levels.full_gain : end_reg;

    assign gain_sum = $signed({2'b00, gain_reg}) + $signed({step_reg[STEP_W-1], step_reg});
    always_comb
    begin
        if (gain_sum < 0)
        begin
            gain_clamped = '0;
        end
        else if (gain_sum[STEP_W:GAIN_W] != '0)
        begin
            gain_clamped = '1;
        end
        else
        begin
            gain_clamped = gain_sum[GAIN_W-1:0];
        end
    end

    // One phase change per cycle; an item leaves only once no phase boundary is pending.
    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        gain_next    = gain_reg;
        step_next    = step_reg;
        end_next     = end_reg;
        div_start    = 1'b0;
        div_from     = '0;
        div_to       = '0;
        div_len      = '0;
        emit         = 1'b0;

        if (state_reg == ST_DIV)
        begin
            if (div_done)
            begin
                step_next  = div_q;
                state_next = ST_EVAL;
            end
        end
        else if (hold_reg)
        begin
            priority if (need_start)
            begin
                started_next = 1'b1;
                phase_next   = PH_ATTACK;
                gain_next    = {levels.attack_level, 16'b0};
                step_next    = '0;
                if (attack_length != '0)
                begin
                    div_start = 1'b1;
                    div_from  = levels.attack_level;
                    div_to    = levels.full_gain;
                    div_len   = attack_length;
                end
            end
            else if (phase_reg == PH_ATTACK && pos_reg >= attack_length)
            begin
                phase_next = PH_HOLD;
                gain_next  = {levels.full_gain, 16'b0};
                step_next  = '0;
            end
            else if ((phase_reg == PH_HOLD && pos_ext >= ah_end && levels.phase_enables[0]))
            begin
                phase_next = PH_DECAY;
                end_next   = levels.sustain_level;
                gain_next  = {levels.full_gain, 16'b0};
                step_next  = '0;
                if (decay_length != '0)
                begin
                    div_start = 1'b1;
                    div_from  = levels.full_gain;
                    div_to    = levels.sustain_level;
                    div_len   = decay_length;
                end
            end
            else if ((phase_reg == PH_HOLD && pos_ext >= ah_end) ||
                     (phase_reg == PH_DECAY && pos_ext >= ahd_end))
            begin
                end_next  = tail_level;
                gain_next = {tail_level, 16'b0};
                step_next = '0;
                if (levels.phase_enables[1])
                begin
                    phase_next = PH_DECAY2;
                    if (total_ext > tail_start)
                    begin
                        div_start = 1'b1;
                        div_from  = tail_level;
                        div_to    = '0;
                        div_len   = tail_len[LENGTH_BITS-1:0];
                    end
                end
                else
                begin
                    phase_next = PH_SUSTAIN;
                end
            end
            else if (phase_reg == PH_DECAY2 && pos_reg >= total_length)
            begin
                phase_next = PH_SILENT;
                gain_next  = '0;
                step_next  = '0;
            end
            else if (!q_full)
            begin
                emit         = 1'b1;
                started_next = 1'b0;
                gain_next    = gain_clamped;
                if (last_reg)
                begin
                    pos_next   = '0;
                    phase_next = PH_ATTACK;
                end
                else if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            if (div_start)
            begin
                state_next = ST_DIV;
            end
        end
    end

    assign diff     = $signed({1'b0, div_to}) - $signed({1'b0, div_from});
    assign diff_mag = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];

    eg_div #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .neg      (diff[LEVEL_W]),
        .num      ({diff_mag, 16'b0}),
        .den      (div_len),
        .done     (div_done),
        .quotient (div_q)
    );

    assign full      = hold_reg && !emit;
    assign accept    = push && !full;
    assign hold_next = accept || (hold_reg && !emit);

    assign q_push        = emit;
    assign q_item.sample = sample_reg;
    assign q_item.last   = last_reg;
    assign q_item.gain   = gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_EVAL;
            hold_reg    <= 1'b0;
            started_reg <= 1'b0;
            pos_reg     <= '0;
            phase_reg   <= PH_ATTACK;
            gain_reg    <= '0;
            step_reg    <= '0;
            end_reg     <= UNITY_LEVEL;
        end
        else
        begin
            state_reg   <= state_next;
            hold_reg    <= hold_next;
            started_reg <= started_next;
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            gain_reg    <= gain_next;
            step_reg    <= step_next;
            end_reg     <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_in;
            last_reg   <= last_in_buffer;
        end
    end

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside of a slope computation");

    a_silent_flat: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SILENT |-> gain_reg == '0 && step_reg == '0)
        else $error("silent phase carries a nonzero gain or slope");
`endif

endmodule

// File: hw/rtl/eg_queue.sv
module eg_queue
    import eg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  eg_item_t push_item,
    output logic     full,
    input  logic     pop,
    output eg_item_t pop_item,
    output logic     empty
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);
    localparam logic [CNT_QW-1:0] DEPTH_CNT = CNT_QW'(Q_DEPTH);

    eg_item_t          mem [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = count_reg == DEPTH_CNT;
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond its depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("item offered to a full queue");
`endif

endmodule

// File: hw/rtl/eg_back.sv
module eg_back
    import eg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  eg_item_t                   q_item,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_out
);

    localparam logic [PROD_W:0]     ROUND_HALF = (PROD_W + 1)'(64'h8000_0000);
    localparam logic [LEVEL_W-1:0]  NEG_LIMIT  = 17'd32768;
    localparam logic [LEVEL_W-1:0]  POS_LIMIT  = 17'd32767;

    logic                p_valid_reg;
    logic [PROD_W-1:0]   p_mag_reg;
    logic                p_neg_reg;
    logic                p_last_reg;
    logic                o_valid_reg;
    logic signed [SAMPLE_W-1:0] o_sample_reg;
    logic                o_last_reg;

    logic                o_take;
    logic                p_take;
    logic [SAMPLE_W:0]   s_ext;
    logic [LEVEL_W-1:0]  s_abs;
    logic [PROD_W:0]     rnd_sum;
    logic [LEVEL_W-1:0]  rnd;
    logic signed [SAMPLE_W-1:0] sat;

    assign o_take = !o_valid_reg || pop;
    assign p_take = !p_valid_reg || o_take;
    assign q_pop  = !q_empty && p_take;

    // Multiply the magnitude so rounding is symmetric around zero.
    assign s_ext = {q_item.sample[SAMPLE_W-1], q_item.sample};
    assign s_abs = q_item.sample[SAMPLE_W-1] ? LEVEL_W'(-s_ext) : LEVEL_W'(s_ext);

    assign rnd_sum = {1'b0, p_mag_reg} + ROUND_HALF;
    assign rnd     = rnd_sum[48:32];

    always_comb
    begin
        if (p_neg_reg)
        begin
            sat = (rnd >= NEG_LIMIT) ? $signed(16'h8000) : $signed(-rnd[SAMPLE_W-1:0]);
        end
        else
        begin
            sat = (rnd >= POS_LIMIT) ? $signed(16'h7FFF) : $signed(rnd[SAMPLE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_take)
            begin
                p_valid_reg <= q_pop;
            end
            if (o_take)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_mag_reg  <= s_abs * q_item.gain;
            p_neg_reg  <= q_item.sample[SAMPLE_W-1];
            p_last_reg <= q_item.last;
        end
        if (o_take && p_valid_reg)
        begin
            o_sample_reg <= sat;
            o_last_reg   <= p_last_reg;
        end
    end

    assign empty      = !o_valid_reg;
    assign sample_out = o_sample_reg;
    assign last_out   = o_last_reg;

endmodule

// File: hw/rtl/envelope_gain_baker.sv
// Envelope gain stage: each 16-bit sample is multiplied by an attack, hold, decay,
// then sustain or fade-to-zero gain and comes back rounded half away from zero and
// saturated. An item flagged last ends the buffer and the next item restarts the
// envelope from the attack, using the registers as they stand then. Steady state is
// one item per cycle while the output keeps popping. Every phase change, including the
// restart at the head of a buffer, stalls the input, and a phase that ramps stalls it
// further while a serial divider works out its slope at one quotient bit per cycle. A
// ramp with a nonzero length always holds the item that enters it, so one item crosses
// at most one ramp start: the worst case is the first item of a buffer that passes the
// restart, hold, an empty decay and a fading tail. A result passes the input register,
// the queue, the product and output registers. The user must write registers only while
// no item is in flight; the block itself does not enforce it.
module envelope_gain_baker
    import eg_pkg::*;
#(
    parameter  int LENGTH_BITS = 20,
    localparam int CFG_W       = (LENGTH_BITS > LEVEL_W) ? LENGTH_BITS : LEVEL_W
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       last_in_buffer,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_out,
    input  logic                       cfg_write,
    input  logic [REG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    logic [LENGTH_BITS-1:0] attack_length_reg;
    logic [LENGTH_BITS-1:0] hold_length_reg;
    logic [LENGTH_BITS-1:0] decay_length_reg;
    logic [LENGTH_BITS-1:0] total_length_reg;
    eg_levels_t             levels_reg;

    logic     mid_push;
    eg_item_t mid_in;
    logic     mid_full;
    logic     mid_pop;
    eg_item_t mid_out;
    logic     mid_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_length_reg        <= '0;
            hold_length_reg          <= '0;
            decay_length_reg         <= '0;
            total_length_reg         <= '0;
            levels_reg.full_gain     <= UNITY_LEVEL;
            levels_reg.attack_level  <= '0;
            levels_reg.sustain_level <= UNITY_LEVEL;
            levels_reg.phase_enables <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ATTACK_LENGTH: attack_length_reg        <= cfg_data[LENGTH_BITS-1:0];
                REG_HOLD_LENGTH:   hold_length_reg          <= cfg_data[LENGTH_BITS-1:0];
                REG_DECAY_LENGTH:  decay_length_reg         <= cfg_data[LENGTH_BITS-1:0];
                REG_TOTAL_LENGTH:  total_length_reg         <= cfg_data[LENGTH_BITS-1:0];
                REG_FULL_GAIN:     levels_reg.full_gain     <= cfg_data[LEVEL_W-1:0];
                REG_ATTACK_LEVEL:  levels_reg.attack_level  <= cfg_data[LEVEL_W-1:0];
                REG_SUSTAIN_LEVEL: levels_reg.sustain_level <= cfg_data[LEVEL_W-1:0];
                REG_PHASE_ENABLES: levels_reg.phase_enables <= cfg_data[1:0];
            endcase
        end
    end

    eg_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .sample_in      (sample_in),
        .last_in_buffer (last_in_buffer),
        .full           (full),
        .attack_length  (attack_length_reg),
        .hold_length    (hold_length_reg),
        .decay_length   (decay_length_reg),
        .total_length   (total_length_reg),
        .levels         (levels_reg),
        .q_push         (mid_push),
        .q_item         (mid_in),
        .q_full         (mid_full)
    );

    eg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_item (mid_in),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_item  (mid_out),
        .empty     (mid_empty)
    );

    eg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (mid_empty),
        .q_item     (mid_out),
        .q_pop      (mid_pop),
        .empty      (empty),
        .pop        (pop),
        .sample_out (sample_out),
        .last_out   (last_out)
    );

endmodule

// File: bench/envelope_gain_checker.sv
`timescale 1ns / 100ps

module envelope_gain_checker
    import eg_pkg::*;
#(
    parameter  int LENGTH_BITS = 20,
    localparam int CFG_W       = (LENGTH_BITS > LEVEL_W) ? LENGTH_BITS : LEVEL_W
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       last_in_buffer,
    input  logic                       empty,
    input  logic                       pop,
    input  logic signed [SAMPLE_W-1:0] sample_out,
    input  logic                       last_out,
    input  logic                       cfg_write,
    input  logic [REG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    output int                         mismatches,
    output int                         outstanding
);

    typedef enum logic [2:0] {
        ENV_ATTACK,
        ENV_HOLD,
        ENV_DECAY,
        ENV_SUSTAIN,
        ENV_FADE,
        ENV_SILENT
    } env_phase_e;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } scaled_t;

    localparam longint GAIN_CEIL = (64'sd1 <<< GAIN_W) - 1;
    localparam longint POS_CEIL  = (64'sd1 <<< LENGTH_BITS) - 1;

    // Register copies.
    longint     attack_len, hold_len, decay_len, total_len;
    longint     full_lvl, attack_lvl, sustain_lvl;
    logic [1:0] enables;

    // Envelope state. The gain is Q1.32 and the step is a signed Q1.32 increment.
    longint     pos, gain, step, end_lvl;
    env_phase_e phase;

    scaled_t scaled_due[$];
    int      mismatch_tally;

    function automatic longint ramp_slope(longint from_lvl, longint to_lvl, longint len);
        if (len == 0)
            return 0;
        return ((to_lvl - from_lvl) * 65536) / len;
    endfunction

    function automatic void open_phase(env_phase_e ph);
        longint fade_start;
        phase = ph;
        step  = 0;
        case (ph)
            ENV_ATTACK:
            begin
                gain = attack_lvl <<< 16;
                step = ramp_slope(attack_lvl, full_lvl, attack_len);
            end
            ENV_HOLD:
                gain = full_lvl <<< 16;
            ENV_DECAY:
            begin
                end_lvl = sustain_lvl;
                gain    = full_lvl <<< 16;
                step    = ramp_slope(full_lvl, sustain_lvl, decay_len);
            end
            ENV_SUSTAIN:
                gain = end_lvl <<< 16;
            ENV_FADE:
            begin
                gain       = end_lvl <<< 16;
                fade_start = attack_len + hold_len + (enables[0] ? decay_len : 64'sd0);
                if (total_len > fade_start)
                    step = ramp_slope(end_lvl, 0, total_len - fade_start);
            end
            default:
            begin
                phase = ENV_SILENT;
                gain  = 0;
            end
        endcase
    endfunction

    function automatic void open_tail();
        if (enables[1])
            open_phase(ENV_FADE);
        else
            open_phase(ENV_SUSTAIN);
    endfunction

    function automatic scaled_t shape_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
        longint  prod, mag, res, next_gain;
        bit      settled;
        scaled_t r;
        if (pos == 0 && phase == ENV_ATTACK)
            open_phase(ENV_ATTACK);
        // Several zero-length phases can be crossed by one item.
        settled = 1'b0;
        repeat (6)
        begin
            if (!settled)
            begin
                if (phase == ENV_ATTACK && pos >= attack_len)
                    open_phase(ENV_HOLD);
                else if (phase == ENV_HOLD && pos >= attack_len + hold_len)
                begin
                    if (enables[0])
                        open_phase(ENV_DECAY);
                    else
                    begin
                        end_lvl = full_lvl;
                        open_tail();
                    end
                end
                else if (phase == ENV_DECAY && pos >= attack_len + hold_len + decay_len)
                    open_tail();
                else if (phase == ENV_FADE && pos >= total_len)
                    open_phase(ENV_SILENT);
                else
                    settled = 1'b1;
            end
        end

        prod = longint'(smp) * gain;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + 64'sh8000_0000) >>> 32;
        if (mag > 32768)
            mag = 32768;
        res = (prod < 0) ? -mag : mag;
        if (res > 32767)
            res = 32767;
        r.sample = res[SAMPLE_W-1:0];
        r.last   = last;

        next_gain = gain + step;
        if (next_gain < 0)
            next_gain = 0;
        if (next_gain > GAIN_CEIL)
            next_gain = GAIN_CEIL;
        gain = next_gain;

        if (last)
        begin
            pos   = 0;
            phase = ENV_ATTACK;
        end
        else if (pos < POS_CEIL)
            pos++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        scaled_t want;
        if (!rst_n)
        begin
            attack_len     = 0;
            hold_len       = 0;
            decay_len      = 0;
            total_len      = 0;
            full_lvl       = 65536;
            attack_lvl     = 0;
            sustain_lvl    = 65536;
            enables        = 2'b00;
            pos            = 0;
            end_lvl        = 65536;
            phase          = ENV_ATTACK;
            gain           = 0;
            step           = 0;
            mismatch_tally = 0;
            scaled_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ATTACK_LENGTH: attack_len  = longint'(cfg_data[LENGTH_BITS-1:0]);
                    REG_HOLD_LENGTH:   hold_len    = longint'(cfg_data[LENGTH_BITS-1:0]);
                    REG_DECAY_LENGTH:  decay_len   = longint'(cfg_data[LENGTH_BITS-1:0]);
                    REG_TOTAL_LENGTH:  total_len   = longint'(cfg_data[LENGTH_BITS-1:0]);
                    REG_FULL_GAIN:     full_lvl    = longint'(cfg_data[LEVEL_W-1:0]);
                    REG_ATTACK_LEVEL:  attack_lvl  = longint'(cfg_data[LEVEL_W-1:0]);
                    REG_SUSTAIN_LEVEL: sustain_lvl = longint'(cfg_data[LEVEL_W-1:0]);
                    REG_PHASE_ENABLES: enables     = cfg_data[1:0];
                    default: ;
                endcase
            end

            if (pop && !empty)
            begin
                if (scaled_due.size() == 0)
                begin
                    $display("%0t checker: item with nothing expected: sample_out %0d last_out %0b",
                             $time, sample_out, last_out);
                    mismatch_tally++;
                end
                else
                begin
                    want = scaled_due.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $display("%0t checker: sample_out expected %0d, got %0d",
                                 $time, want.sample, sample_out);
                        mismatch_tally++;
                    end
                    if (last_out !== want.last)
                    begin
                        $display("%0t checker: last_out expected %0b, got %0b",
                                 $time, want.last, last_out);
                        mismatch_tally++;
                    end
                end
            end

            if (push && !full)
                scaled_due.insert(scaled_due.size(), shape_sample(sample_in, last_in_buffer));

            mismatches  <= mismatch_tally;
            outstanding <= scaled_due.size();
        end
    end

endmodule

// File: bench/envelope_gain_baker_test.sv
`timescale 1ns / 100ps

module envelope_gain_baker_test;
    import eg_pkg::*;

    localparam int LENGTH_BITS  = 20;
    localparam int CFG_W        = (LENGTH_BITS > LEVEL_W) ? LENGTH_BITS : LEVEL_W;
    localparam int RANDOM_ITEMS = 1125;
    localparam int STALL_CYCLES = 300;

    localparam logic [CFG_W-1:0] LENGTH_MAX = CFG_W'((64'd1 << LENGTH_BITS) - 64'd1);

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in_buffer;
    logic                       empty;
    logic                       pop;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
    logic                       cfg_write;
    logic [REG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    int mismatches;
    int outstanding;
    int send_idle_pct;
    int take_idle_pct;
    int hold_asks;

    envelope_gain_baker #(.LENGTH_BITS(LENGTH_BITS)) u_top (.*);

    envelope_gain_checker #(.LENGTH_BITS(LENGTH_BITS)) u_check (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random pops, plus a long hold-off whenever one is asked for.
    initial
    begin : taker
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_asks)
            begin
                holds_seen = hold_asks;
                hold_left  = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2:
            begin
                v = int'($urandom_range(2)) - 1;
                return v[SAMPLE_W-1:0];
            end
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_length(input int span);
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 88)
            return CFG_W'($urandom_range(span, 1));
        return LENGTH_MAX - CFG_W'($urandom_range(3));
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 30)
            return UNITY_LEVEL;
        return LEVEL_W'($urandom_range(65536));
    endfunction

    task automatic offer(input logic signed [SAMPLE_W-1:0] smp, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        sample_in      <= smp;
        last_in_buffer <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stop offering and wait until every item has come back out.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_envelope(input logic [CFG_W-1:0] a_len, h_len, d_len, t_len,
                                    input logic [LEVEL_W-1:0] full_g, a_lvl, s_lvl,
                                    input logic [1:0] en);
        drain();
        write_reg(REG_ATTACK_LENGTH, a_len);
        write_reg(REG_HOLD_LENGTH, h_len);
        write_reg(REG_DECAY_LENGTH, d_len);
        write_reg(REG_TOTAL_LENGTH, t_len);
        write_reg(REG_FULL_GAIN, CFG_W'(full_g));
        write_reg(REG_ATTACK_LEVEL, CFG_W'(a_lvl));
        write_reg(REG_SUSTAIN_LEVEL, CFG_W'(s_lvl));
        write_reg(REG_PHASE_ENABLES, CFG_W'(en));
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        int sent;
        int setting;
        int next_change;
        int buf_len;
        rst_n          <= 1'b0;
        push           <= 1'b0;
        sample_in      <= '0;
        last_in_buffer <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= REG_ATTACK_LENGTH;
        cfg_data       <= '0;
        take_idle_pct  <= 0;
        hold_asks      <= 0;
        send_idle_pct  = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers give unity gain, so extremes pass straight through.
        offer(16'sh7FFF, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'sh0000, 1'b0);
        offer(-16'sd1, 1'b0);
        offer(16'sd1, 1'b1);

        // One buffer that walks attack, hold, decay, fade and then silence.
        program_envelope(20'd4, 20'd2, 20'd3, 20'd13, UNITY_LEVEL, 17'd0, 17'd32768, 2'b11);
        for (int k = 0; k < 16; k++)
            offer(k[0] ? 16'sh8000 : 16'sh7FFF, k == 15);

        // Half gain in sustain: exact halves round away from zero.
        program_envelope(20'd0, 20'd0, 20'd0, 20'd0, 17'd32768, UNITY_LEVEL, 17'd0, 2'b00);
        offer(16'sd1, 1'b0);
        offer(-16'sd1, 1'b0);
        offer(16'sd3, 1'b1);

        sent        = 0;
        setting     = 0;
        next_change = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= next_change)
            begin
                case (setting)
                    0: program_envelope(LENGTH_MAX, LENGTH_MAX, LENGTH_MAX, LENGTH_MAX,
                                        UNITY_LEVEL, '0, '0, 2'b11);
                    1: program_envelope('0, '0, '0, '0, '0, UNITY_LEVEL, UNITY_LEVEL, 2'b11);
                    default: program_envelope(pick_length(12), pick_length(12), pick_length(12),
                                               pick_length(80), pick_level(), pick_level(),
                                               pick_level(), 2'($urandom_range(3)));
                endcase
                if (setting == 2 || setting == 9)
                    hold_asks <= hold_asks + 1;
                setting++;
                next_change = sent + 96;
            end

            if (sent < 384)
            begin
                send_idle_pct = 12;
                take_idle_pct <= 71;
            end
            else if (sent < 768)
            begin
                send_idle_pct = 71;
                take_idle_pct <= 12;
            end
            else
            begin
                send_idle_pct = 0;
                take_idle_pct <= 0;
            end

            buf_len = ($urandom_range(99) < 80) ? $urandom_range(48, 1) : $urandom_range(120, 49);
            for (int k = 0; k < buf_len; k++)
                offer(pick_sample(), k == buf_len - 1);
            sent += buf_len;
        end

        drain();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
